/* sv/assert_macros.svh */
// Assertion macros used by the cache RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that an implication holds on every rising clock edge, off during reset
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

/* sv/lkvc_pkg.sv */
// Shared constants and types of the LRU key/value cache
package lkvc_pkg;

    localparam int ENTRIES_DEFAULT   = 16;
    localparam int KEY_BITS_DEFAULT  = 32;
    localparam int ITEM_BITS_DEFAULT = 32;

    localparam int         CAP_BITS  = 5;
    localparam logic [4:0] CAP_RESET = 5'd16;

    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Broadcast update command from the control logic to every entry
    typedef struct packed {
        logic load;   // write key/item into the selected entry and mark it valid
        logic age;    // make the selected entry most recent, age the ones below limit
    } entry_cmd_t;

endpackage

/* sv/lru_key_value_cache.sv */
// Fully associative key/value cache with least-recently-used replacement.
// Input reg, then result reg; all entries compare the key in parallel in the compute stage.
// Throughput: one word per cycle while the result register is not stalled by m_axis_tready.
// Reset: clears all valid bits, ranks and the fill count, and sets capacity to 16.
// Stored keys and items are not reset; only valid entries are ever read.
module lru_key_value_cache #(
    parameter int ENTRIES   = lkvc_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS  = lkvc_pkg::KEY_BITS_DEFAULT,
    parameter int ITEM_BITS = lkvc_pkg::ITEM_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lkvc_pkg::CAP_BITS-1:0]     cfg_wr_data,   // capacity
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [KEY_BITS-1:0] lookup_key, then item_value, zero padded to whole bytes
    input  logic [((KEY_BITS+ITEM_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                              s_axis_tuser,  // operation
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [ITEM_BITS-1:0] found_item, zero padded to whole bytes
    output logic [((ITEM_BITS+7)/8)*8-1:0]    m_axis_tdata,
    output logic                              m_axis_tuser   // success
);

    localparam int OUT_W  = ((ITEM_BITS + 7) / 8) * 8;
    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > lkvc_pkg::CAP_BITS) ? OCC_W : lkvc_pkg::CAP_BITS;

    logic [lkvc_pkg::CAP_BITS-1:0] cap_reg;

    logic                 in_valid_reg;
    logic                 in_op_reg;
    logic [KEY_BITS-1:0]  in_key_reg;
    logic [ITEM_BITS-1:0] in_item_reg;

    logic                 out_valid_reg;
    logic                 out_success_reg;
    logic [ITEM_BITS-1:0] out_item_reg;

    logic [OCC_W-1:0]     occ_reg;
    logic [OCC_W-1:0]     occ_next;

    logic                 s_accept;
    logic                 advance;

    logic [ENTRIES-1:0]   valid_vec;
    logic [ENTRIES-1:0]   hit_vec;
    logic [ENTRIES-1:0]   free_vec;
    logic [ENTRIES-1:0]   victim_vec;
    logic [ENTRIES-1:0]   sel_vec;
    logic [RANK_W-1:0]    rank_arr [ENTRIES];
    logic [ITEM_BITS-1:0] item_arr [ENTRIES];

    logic                 any_hit;
    logic                 any_free;
    logic [ITEM_BITS-1:0] hit_item;
    logic [RANK_W-1:0]    hit_rank;
    logic [RANK_W-1:0]    lru_rank;
    logic [CMP_W-1:0]     eff_cap;
    logic                 evict;
    logic                 is_find;
    logic                 find_hit;
    logic                 ins_ok;
    logic [OCC_W-1:0]     limit;
    lkvc_pkg::entry_cmd_t cmd;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Capacity clamped to 1..ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (int'(cap_reg) > ENTRIES)
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = CMP_W'(cap_reg);
        end
    end

    // Ranks of valid entries are distinct 0..occ-1, so the LRU entry holds occ-1
    assign lru_rank = RANK_W'(occ_reg - OCC_W'(1));

    always_comb
    begin
        hit_item = '0;
        hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_vec[i])
            begin
                hit_item = hit_item | item_arr[i];
                hit_rank = hit_rank | rank_arr[i];
            end
            victim_vec[i] = valid_vec[i] && (rank_arr[i] == lru_rank);
        end
    end

    // Lowest free entry
    assign free_vec = ~valid_vec & (valid_vec + ENTRIES'(1));
    assign any_free = |free_vec;
    assign any_hit  = |hit_vec;
    assign evict    = (CMP_W'(occ_reg) >= eff_cap) && (occ_reg != '0);
    assign is_find  = (in_op_reg == lkvc_pkg::OP_FIND);
    assign find_hit = is_find && any_hit;
    assign ins_ok   = (in_op_reg == lkvc_pkg::OP_INSERT) && (in_item_reg != '0) && !any_hit
                      && (evict || any_free);

    always_comb
    begin
        if (is_find)
        begin
            sel_vec = hit_vec;
            limit   = OCC_W'(hit_rank);
        end
        else if (evict)
        begin
            sel_vec = victim_vec;
            limit   = OCC_W'(lru_rank);
        end
        else
        begin
            sel_vec = free_vec;
            limit   = OCC_W'(ENTRIES);
        end
        cmd.load = advance && ins_ok;
        cmd.age  = advance && (find_hit || ins_ok);
    end

    assign occ_next = (cmd.load && !evict) ? occ_reg + OCC_W'(1) : occ_reg;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_entry
        lkvc_entry #(
            .ENTRIES   (ENTRIES),
            .KEY_BITS  (KEY_BITS),
            .ITEM_BITS (ITEM_BITS)
        ) u_entry (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .sel         (sel_vec[g]),
            .limit       (limit),
            .key         (in_key_reg),
            .item        (in_item_reg),
            .valid       (valid_vec[g]),
            .match       (hit_vec[g]),
            .rank        (rank_arr[g]),
            .stored_item (item_arr[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lkvc_pkg::CAP_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            occ_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            occ_reg <= occ_next;
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_op_reg   <= s_axis_tuser;
            in_key_reg  <= s_axis_tdata[KEY_BITS-1:0];
            in_item_reg <= s_axis_tdata[KEY_BITS+ITEM_BITS-1:KEY_BITS];
        end
        if (advance)
        begin
            out_success_reg <= is_find ? any_hit : ins_ok;
            out_item_reg    <= find_hit ? hit_item : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_success_reg;
    assign m_axis_tdata  = OUT_W'(out_item_reg);

`include "assert_macros.svh"

    `ASSERT_CLK(a_unique_hit, $onehot0(hit_vec), "key matches more than one entry")
    `ASSERT_CLK(a_fill_count, $countones(valid_vec) == int'(occ_reg),
        "fill count differs from number of valid entries")
    `ASSERT_IMPL(a_one_victim, cmd.load && evict, $onehot(victim_vec),
        "eviction without exactly one least recent entry")

endmodule

/* sv/lkvc_entry.sv */
// One entry of the cache: key, item, valid bit and recency rank with key compare
module lkvc_entry #(
    parameter int ENTRIES   = lkvc_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS  = lkvc_pkg::KEY_BITS_DEFAULT,
    parameter int ITEM_BITS = lkvc_pkg::ITEM_BITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lkvc_pkg::entry_cmd_t       cmd,
    input  logic                       sel,
    input  logic [$clog2(ENTRIES+1)-1:0] limit,
    input  logic [KEY_BITS-1:0]        key,
    input  logic [ITEM_BITS-1:0]       item,
    output logic                       valid,
    output logic                       match,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rank,
    output logic [ITEM_BITS-1:0]       stored_item
);

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LIM_W  = $clog2(ENTRIES + 1);

    logic                 valid_reg;
    logic                 valid_next;
    logic [RANK_W-1:0]    rank_reg;
    logic [RANK_W-1:0]    rank_next;
    logic [KEY_BITS-1:0]  key_reg;
    logic [ITEM_BITS-1:0] item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (cmd.load && sel)
        begin
            valid_next = 1'b1;
        end
        if (cmd.age && sel)
        begin
            rank_next = '0;
        end
        else if (cmd.age && valid_reg && (LIM_W'(rank_reg) < limit))
        begin
            rank_next = rank_reg + RANK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && sel)
        begin
            key_reg  <= key;
            item_reg <= item;
        end
    end

    assign valid       = valid_reg;
    assign match       = valid_reg && (key_reg == key);
    assign rank        = rank_reg;
    assign stored_item = item_reg;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the LRU key/value cache: queued stream driver, shadow cache, monitor.
module tb_top;

    localparam int          ENTRIES     = lkvc_pkg::ENTRIES_DEFAULT;
    localparam int          POOL_KEYS   = 20;
    localparam int          TAIL_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct {
        logic        op;
        logic [31:0] key;
        logic [31:0] item;
    } cache_request_t;

    typedef struct {
        logic        success;
        logic [31:0] found_item;
    } cache_answer_t;

    logic                          clk            = 1'b0;
    logic                          rst_n          = 1'b0;
    logic                          cfg_wr_en      = 1'b0;
    logic [lkvc_pkg::CAP_BITS-1:0] cfg_wr_data    = '0;
    logic                          s_axis_tvalid  = 1'b0;
    logic                          s_axis_tready;
    logic [63:0]                   s_axis_tdata   = '0;   // [31:0] lookup_key, [63:32] item_value
    logic                          s_axis_tuser   = 1'b0; // operation
    logic                          m_axis_tvalid;
    logic                          m_axis_tready  = 1'b0;
    logic [31:0]                   m_axis_tdata;          // [31:0] found_item
    logic                          m_axis_tuser;          // success

    cache_request_t request_q[$];
    cache_answer_t  expected_answers[$];

    // Shadow copy of the cache contents and recency order
    logic [31:0]                   shadow_key   [ENTRIES];
    logic [31:0]                   shadow_item  [ENTRIES];
    logic                          shadow_valid [ENTRIES];
    int                            shadow_rank  [ENTRIES];
    int                            shadow_count;
    logic [lkvc_pkg::CAP_BITS-1:0] shadow_capacity;

    logic [31:0] key_pool[POOL_KEYS];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          mismatch_seen  = 1'b0;
    int unsigned cycle_count    = 0;

    lru_key_value_cache i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Move slot to rank 0; valid entries ranked below limit age by one
    task automatic make_most_recent(input int slot, input int limit);
        int i;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (shadow_valid[i] && i != slot && shadow_rank[i] < limit)
                shadow_rank[i]++;
        end
        shadow_rank[slot] = 0;
    endtask

    task automatic predict_cache_access(input logic op, input logic [31:0] key,
                                        input logic [31:0] item);
        int            i;
        int            hit;
        int            slot;
        int            worst;
        int            cap;
        cache_answer_t ans;
        hit   = -1;
        slot  = -1;
        worst = 0;
        ans.success    = 1'b0;
        ans.found_item = '0;
        cap = int'(shadow_capacity);
        if (cap == 0)
            cap = 1;
        else if (cap > ENTRIES)
            cap = ENTRIES;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && shadow_valid[i] && shadow_key[i] == key)
                hit = i;
        end
        if (op == lkvc_pkg::OP_FIND)
        begin
            if (hit >= 0)
            begin
                make_most_recent(hit, shadow_rank[hit]);
                ans.success    = 1'b1;
                ans.found_item = shadow_item[hit];
            end
        end
        else if (item != '0 && hit < 0)
        begin
            if (shadow_count >= cap && shadow_count > 0)
            begin
                // replace the least recent entry, occupancy unchanged
                for (i = 0; i < ENTRIES; i++)
                begin
                    if (shadow_valid[i] && (slot < 0 || shadow_rank[i] >= worst))
                    begin
                        worst = shadow_rank[i];
                        slot  = i;
                    end
                end
                shadow_key[slot]  = key;
                shadow_item[slot] = item;
                make_most_recent(slot, worst);
            end
            else
            begin
                for (i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (!shadow_valid[i])
                        slot = i;
                end
                shadow_valid[slot] = 1'b1;
                shadow_key[slot]   = key;
                shadow_item[slot]  = item;
                make_most_recent(slot, ENTRIES);
                shadow_count++;
            end
            ans.success = 1'b1;
        end
        expected_answers.push_back(ans);
    endtask

    // Driver: hold each word until accepted, predict it at the accepting edge
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        cache_request_t req;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_cache_access(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {req.item, req.key};
                    s_axis_tuser  <= req.op;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result word with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        cache_answer_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("unexpected result word: success=%0b found_item=%h",
                           m_axis_tuser, m_axis_tdata);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (m_axis_tuser !== want.success)
                    begin
                        $error("success: expected %0b, got %0b", want.success, m_axis_tuser);
                        mismatch_seen = 1'b1;
                    end
                    if (m_axis_tdata !== want.found_item)
                    begin
                        $error("found_item: expected %h, got %h", want.found_item,
                               m_axis_tdata);
                        mismatch_seen = 1'b1;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_request(input logic op, input logic [31:0] key,
                                 input logic [31:0] item);
        cache_request_t req;
        req.op   = op;
        req.key  = key;
        req.item = item;
        request_q.push_back(req);
    endtask

    // Block until every queued word is accepted and every result has come back
    task automatic wait_drained();
        @(negedge clk);
        while (request_q.size() > 0 || s_axis_tvalid || expected_answers.size() > 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(input logic [lkvc_pkg::CAP_BITS-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en       <= 1'b0;
        shadow_capacity  = value;
        @(negedge clk);
    endtask

    // Mostly keys from a small pool so finds hit and inserts collide
    task automatic queue_random_requests(input int count);
        int          n;
        logic        op;
        logic [31:0] key;
        logic [31:0] item;
        for (n = 0; n < count; n++)
        begin
            op   = $urandom_range(1) ? lkvc_pkg::OP_INSERT : lkvc_pkg::OP_FIND;
            key  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_KEYS - 1)]
                                              : $urandom;
            item = ($urandom_range(99) < 10) ? 32'h0 : $urandom;
            queue_request(op, key, item);
        end
    endtask

    initial
    begin : stimulus
        int i;
        for (i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = 0;
            shadow_key[i]   = '0;
            shadow_item[i]  = '0;
        end
        shadow_count    = 0;
        shadow_capacity = lkvc_pkg::CAP_RESET;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (i = 2; i < POOL_KEYS; i++)
            key_pool[i] = $urandom;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty cache, null item, duplicate key, extreme keys and items
        queue_request(lkvc_pkg::OP_FIND,   32'h0000_0000, 32'h0000_0000);
        queue_request(lkvc_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        queue_request(lkvc_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0001);
        queue_request(lkvc_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(lkvc_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0005);
        queue_request(lkvc_pkg::OP_FIND,   32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(lkvc_pkg::OP_FIND,   32'hFFFF_FFFF, 32'h0000_0000);
        queue_request(lkvc_pkg::OP_FIND,   32'h1234_5678, 32'hA5A5_A5A5);
        wait_drained();

        // Zero capacity acts as one; occupancy already above it
        write_capacity(5'd0);
        queue_request(lkvc_pkg::OP_INSERT, 32'h0000_0007, 32'h0000_0070);
        queue_request(lkvc_pkg::OP_FIND,   32'h0000_0000, 32'h0000_0000);
        queue_request(lkvc_pkg::OP_FIND,   32'h0000_0007, 32'h0000_0000);
        queue_request(lkvc_pkg::OP_INSERT, 32'h0000_0007, 32'h0000_0071);
        wait_drained();

        // Capacity above the entry count acts as the entry count
        write_capacity(5'd31);
        queue_request(lkvc_pkg::OP_INSERT, 32'h0000_0008, 32'h0000_0080);
        queue_request(lkvc_pkg::OP_INSERT, 32'h0000_0009, 32'h0000_0090);
        queue_request(lkvc_pkg::OP_FIND,   32'h0000_0007, 32'h0000_0000);
        wait_drained();

        // Lowered below occupancy: evict in recency order
        write_capacity(5'd2);
        queue_request(lkvc_pkg::OP_INSERT, 32'h0000_000A, 32'h0000_0100);
        queue_request(lkvc_pkg::OP_FIND,   32'h0000_0008, 32'h0000_0000);
        queue_request(lkvc_pkg::OP_INSERT, 32'h0000_000B, 32'h0000_0110);
        queue_request(lkvc_pkg::OP_FIND,   32'h0000_0009, 32'h0000_0000);
        queue_request(lkvc_pkg::OP_FIND,   32'h0000_000B, 32'h0000_0000);
        wait_drained();

        write_capacity(5'd16);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_requests(100);
        wait_drained();

        write_capacity(5'd3);
        send_idle_pct  = 80;
        recv_stall_pct = 0;
        queue_random_requests(80);
        wait_drained();

        write_capacity(5'd31);
        send_idle_pct  = 0;
        recv_stall_pct = 80;
        queue_random_requests(100);
        wait_drained();

        write_capacity(5'd1);
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        queue_random_requests(60);
        wait_drained();

        write_capacity(5'd8);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_requests(60);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (!mismatch_seen && expected_answers.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
